/* design/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sad search check failed");

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sad search check failed");

`endif

/* design/sadbm_pkg.sv */
// types and constants of the sad patch best match search
package sadbm_pkg;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 16;
    localparam int SAD_W       = 21;
    localparam int CFG_W       = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int DIFF_W      = PIX_W + 2;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = CFG_W'(480);
    localparam logic [SAD_W-1:0] SAD_SAT            = {SAD_W{1'b1}};

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_CAND = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        op_t                op;
        logic [PIX_W-1:0]   pixel_red;
        logic [PIX_W-1:0]   pixel_green;
        logic [PIX_W-1:0]   pixel_blue;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               last_in_patch;
        logic               last_candidate;
    } pix_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] best_x;
        logic [COORD_W-1:0] best_y;
        logic [SAD_W-1:0]   best_sad;
        logic               found;
    } res_word_t;

endpackage

/* design/sad_patch_best_match_search.sv */
// top level of the sad patch best match search
//
// pix channel: one pixel word per accepted item (pix_valid high, pix_stall low).
//   op = load writes the next reference pixel in row-major order, op = candidate
//   compares one candidate pixel against the reference pixel at the same place.
// res channel: one result word after the last pixel of the last candidate,
//   held in an output register until taken (res_valid high, res_stall low).
// cfg channel: image width and height for the bounds check; cfg_ready is
//   always high, writes are expected only while the block is idle.
// throughput: one pixel word per cycle while not stalled; the single-port reference
//   ram gives one read (candidate) or one write (load) per cycle.
// result path: the final pixel word passes the accumulate and bounds check stage,
//   then the best-match update stage, then res_valid rises in the output register.
// stalls: a waiting result does not block new pixels; pix_stall rises only
//   when a second result reaches the last stage while the first still waits.
// reset: counters, running sum, best match and valid flags clear at once,
//   image size goes to 640 x 480; the reference ram is not cleared and must
//   be loaded before candidates are sent.
// bounds: a candidate counts only if its centre is at least half a patch
//   inside every image edge, compared in sub-pixel fixed point.
`include "assert_macros.svh"

module sad_patch_best_match_search #(
    parameter int PATCH_SIDE      = 38,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  sadbm_pkg::pix_word_t                pix_word,
    output logic                                res_valid,
    input  logic                                res_stall,
    output sadbm_pkg::res_word_t                res_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sadbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sadbm_pkg::CFG_W-1:0]         cfg_data
);
    import sadbm_pkg::*;

    // patch geometry: odd sides are lowered to even
    localparam int SIDE   = PATCH_SIDE - (PATCH_SIDE % 2);
    localparam int HALF   = SIDE / 2;
    localparam int AREA   = SIDE * SIDE;
    localparam int ADDR_W = $clog2(AREA);
    localparam int CNT_W  = $clog2(AREA + 1);
    // width that holds both centre + half and the scaled image size
    localparam int CMP_W  = (COORD_W + 1 > CFG_W + COORD_FRAC_BITS) ?
                            COORD_W + 1 : CFG_W + COORD_FRAC_BITS;

    localparam logic [CNT_W-1:0] AREA_CNT = CNT_W'(AREA);
    localparam logic [CMP_W-1:0] HALF_FX  = CMP_W'(HALF) << COORD_FRAC_BITS;

    // configuration
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;

    // front: counters and reference ram
    logic [CNT_W-1:0]       load_idx_reg, load_idx_next;
    logic [CNT_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [3*PIX_W-1:0]     ref_mem [AREA];
    logic [3*PIX_W-1:0]     ref_rd_reg;

    // stage 1: pixel difference and accumulation
    logic                   s1_valid_reg;
    logic                   s1_in_range_reg;
    logic [PIX_W-1:0]       s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [COORD_W-1:0]     s1_cx_reg, s1_cy_reg;
    logic                   s1_last_reg, s1_last_cand_reg;
    logic [SAD_W-1:0]       running_sad_reg, running_sad_next;

    // stage 2: best-match update
    logic                   s2_valid_reg;
    logic [SAD_W-1:0]       s2_sum_reg;
    logic [COORD_W-1:0]     s2_cx_reg, s2_cy_reg;
    logic                   s2_inside_reg;
    logic                   s2_last_cand_reg;
    logic [SAD_W-1:0]       best_sum_reg;
    logic [COORD_W-1:0]     best_col_reg, best_row_reg;
    logic                   any_found_reg;

    // output register
    logic                   res_valid_reg;
    res_word_t              res_word_reg;

    logic                   hold;
    logic                   advance;
    logic                   pix_accept;
    logic                   s2_emit;

    logic [DIFF_W-1:0]      diff_sum;
    logic [SAD_W:0]         sum_wide;
    logic [SAD_W-1:0]       sum_sat;
    logic                   in_image;

    logic                   better;
    logic [SAD_W-1:0]       nb_sum;
    logic [COORD_W-1:0]     nb_col, nb_row;
    logic                   nb_found;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

    // pipeline holds only when a result is ready but the output is still full
    assign s2_emit    = s2_valid_reg && s2_last_cand_reg;
    assign hold       = res_valid_reg && res_stall && s2_emit;
    assign advance    = !hold;
    assign pix_stall  = hold;
    assign pix_accept = pix_valid && advance;
    assign cfg_ready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // load and compare counters; pixels past the patch area are dropped
    always_comb
    begin
        load_idx_next = load_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        if (pix_accept)
        begin
            if (pix_word.op == OP_LOAD)
            begin
                if (pix_word.last_in_patch)
                    load_idx_next = '0;
                else if (load_idx_reg < AREA_CNT)
                    load_idx_next = load_idx_reg + CNT_W'(1);
            end
            else
            begin
                if (pix_word.last_in_patch)
                    cmp_idx_next = '0;
                else if (cmp_idx_reg < AREA_CNT)
                    cmp_idx_next = cmp_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
            cmp_idx_reg  <= '0;
        end
        else
        begin
            load_idx_reg <= load_idx_next;
            cmp_idx_reg  <= cmp_idx_next;
        end
    end

    // reference ram: write on load, registered read on candidate
    always_ff @(posedge clk)
    begin
        if (pix_accept && pix_word.op == OP_LOAD && load_idx_reg < AREA_CNT)
            ref_mem[load_idx_reg[ADDR_W-1:0]] <=
                {pix_word.pixel_red, pix_word.pixel_green, pix_word.pixel_blue};
        if (pix_accept && pix_word.op == OP_CAND)
            ref_rd_reg <= ref_mem[cmp_idx_reg[ADDR_W-1:0]];
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= pix_accept && pix_word.op == OP_CAND;
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_in_range_reg  <= cmp_idx_reg < AREA_CNT;
            s1_red_reg       <= pix_word.pixel_red;
            s1_green_reg     <= pix_word.pixel_green;
            s1_blue_reg      <= pix_word.pixel_blue;
            s1_cx_reg        <= pix_word.center_x;
            s1_cy_reg        <= pix_word.center_y;
            s1_last_reg      <= pix_word.last_in_patch;
            s1_last_cand_reg <= pix_word.last_candidate;
        end
    end

    // three-channel difference, saturating accumulate, bounds check
    always_comb
    begin
        diff_sum = '0;
        if (s1_in_range_reg)
            diff_sum = DIFF_W'(abs_diff(s1_red_reg,   ref_rd_reg[3*PIX_W-1:2*PIX_W]))
                     + DIFF_W'(abs_diff(s1_green_reg, ref_rd_reg[2*PIX_W-1:PIX_W]))
                     + DIFF_W'(abs_diff(s1_blue_reg,  ref_rd_reg[PIX_W-1:0]));
        sum_wide = {1'b0, running_sad_reg} + (SAD_W + 1)'(diff_sum);
        sum_sat  = sum_wide[SAD_W] ? SAD_SAT : sum_wide[SAD_W-1:0];

        in_image = (CMP_W'(s1_cx_reg) >= HALF_FX)
                && (CMP_W'(s1_cy_reg) >= HALF_FX)
                && (CMP_W'(s1_cx_reg) + HALF_FX
                    < (CMP_W'(image_width_reg) << COORD_FRAC_BITS))
                && (CMP_W'(s1_cy_reg) + HALF_FX
                    < (CMP_W'(image_height_reg) << COORD_FRAC_BITS));

        running_sad_next = running_sad_reg;
        if (s1_valid_reg)
            running_sad_next = s1_last_reg ? '0 : sum_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sad_reg <= '0;
            s2_valid_reg    <= 1'b0;
        end
        else if (advance)
        begin
            running_sad_reg <= running_sad_next;
            s2_valid_reg    <= s1_valid_reg && s1_last_reg;
        end
    end

    // stage 2 payload: a finished candidate
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_sum_reg       <= sum_sat;
            s2_cx_reg        <= s1_cx_reg;
            s2_cy_reg        <= s1_cy_reg;
            s2_inside_reg    <= in_image;
            s2_last_cand_reg <= s1_last_cand_reg;
        end
    end

    // best match so far including the candidate in stage 2; first wins a tie
    always_comb
    begin
        better   = s2_inside_reg && (!any_found_reg || s2_sum_reg < best_sum_reg);
        nb_sum   = better ? s2_sum_reg : best_sum_reg;
        nb_col   = better ? s2_cx_reg  : best_col_reg;
        nb_row   = better ? s2_cy_reg  : best_row_reg;
        nb_found = any_found_reg || better;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg  <= '0;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
            any_found_reg <= 1'b0;
        end
        else if (advance && s2_valid_reg)
        begin
            if (s2_last_cand_reg)
            begin
                // search done, start the next one clean
                best_sum_reg  <= '0;
                best_col_reg  <= '0;
                best_row_reg  <= '0;
                any_found_reg <= 1'b0;
            end
            else
            begin
                best_sum_reg  <= nb_sum;
                best_col_reg  <= nb_col;
                best_row_reg  <= nb_row;
                any_found_reg <= nb_found;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance && s2_emit)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_emit)
        begin
            res_word_reg.best_x   <= nb_col;
            res_word_reg.best_y   <= nb_row;
            res_word_reg.best_sad <= nb_sum;
            res_word_reg.found    <= nb_found;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    `ASSERT_ALWAYS(a_load_idx_bound, clk, rst_n, load_idx_reg <= AREA_CNT)
    `ASSERT_ALWAYS(a_cmp_idx_bound, clk, rst_n, cmp_idx_reg <= AREA_CNT)
    `ASSERT_IMPLIES(a_not_found_zero, clk, rst_n, res_valid && !res_word.found, res_word.best_sad == '0 && res_word.best_x == '0 && res_word.best_y == '0)
    `ASSERT_IMPLIES(a_result_from_last, clk, rst_n, $rose(res_valid_reg), $past(s2_valid_reg && s2_last_cand_reg))

endmodule

/* dv/tb.sv */
// testbench of the sad patch best match search, self-checking against its own match predictor
module tb;
    import sadbm_pkg::*;

    // geometry of the block as built here: an odd side request would be made even
    localparam int PATCH_SIDE    = 38;
    localparam int COORD_FRAC    = 4;
    localparam int SIDE          = PATCH_SIDE - PATCH_SIDE % 2;
    localparam int HALF_SIDE     = SIDE / 2;
    localparam int AREA          = SIDE * SIDE;
    localparam int MAX_LEN       = 40;        // longest candidate in the random searches
    localparam int REF_LOAD_LEN  = MAX_LEN + 4; // reference prefix that the searches read
    localparam int SETTLE_CYCLES = 8;         // settle time for the pipeline after results drain
    localparam int HOLD_CYCLES   = 300;       // long result hold-off in the pressure test
    localparam int CYCLE_LIMIT   = 1000000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       pix_valid = 1'b0;
    logic       pix_stall;
    pix_word_t  pix_word  = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_word_t  res_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    // pacing knobs: source gaps, sink stalls, and the long hold of the pressure test
    bit   src_idle     = 1'b1;
    logic sink_idle    = 1'b1;
    logic hold_results = 1'b0;

    // predictor state, kept in step with every accepted pixel word
    logic [CFG_W-1:0]   img_w = IMAGE_WIDTH_RESET;
    logic [CFG_W-1:0]   img_h = IMAGE_HEIGHT_RESET;
    logic [23:0]        ref_pix [AREA];
    int unsigned        load_ptr = 0;
    int unsigned        cmp_ptr  = 0;
    logic [SAD_W-1:0]   run_sum  = '0;
    logic [SAD_W-1:0]   best_sum = '0;
    logic [COORD_W-1:0] best_cx  = '0;
    logic [COORD_W-1:0] best_cy  = '0;
    bit                 have_best = 1'b0;
    res_word_t          pending_matches [$];

    int unsigned n_words        = 0;
    int unsigned n_results      = 0;
    int unsigned n_outside      = 0;
    int unsigned n_sizes        = 0;
    int unsigned n_stall_cycles = 0;
    int unsigned n_cycles       = 0;
    int unsigned n_errors       = 0;

    sad_patch_best_match_search #(
        .PATCH_SIDE      (PATCH_SIDE),
        .COORD_FRAC_BITS (COORD_FRAC)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int abs_diff(input logic [7:0] a, input logic [7:0] b);
        return a > b ? int'(a - b) : int'(b - a);
    endfunction

    // centre at least half a patch inside every edge, exact in sub-pixel units
    function automatic bit in_bounds(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
        int unsigned h;
        int unsigned wl;
        int unsigned hl;
        h  = HALF_SIDE << COORD_FRAC;
        wl = 32'(img_w) << COORD_FRAC;
        hl = 32'(img_h) << COORD_FRAC;
        return 32'(cx) >= h && 32'(cy) >= h && 32'(cx) + h < wl && 32'(cy) + h < hl;
    endfunction

    // advance the match state by one accepted word; queue the result a search closes
    function automatic void apply_pixel_word(input pix_word_t w);
        logic [23:0] px;
        int unsigned sum;
        res_word_t   r;
        if (w.op == OP_LOAD)
        begin
            if (load_ptr < AREA)
            begin
                ref_pix[load_ptr] = {w.pixel_red, w.pixel_green, w.pixel_blue};
                load_ptr++;
            end
            // a closing load restarts the reference at entry zero
            if (w.last_in_patch)
                load_ptr = 0;
            return;
        end
        // pixels past the patch area are dropped
        if (cmp_ptr < AREA)
        begin
            px  = ref_pix[cmp_ptr];
            sum = 32'(run_sum) + abs_diff(w.pixel_red, px[23:16])
                + abs_diff(w.pixel_green, px[15:8]) + abs_diff(w.pixel_blue, px[7:0]);
            run_sum = sum > 32'(SAD_SAT) ? SAD_SAT : SAD_W'(sum);
            cmp_ptr++;
        end
        if (!w.last_in_patch)
            return;
        // centre and last flag count only on the closing word; ties keep the first
        if (!in_bounds(w.center_x, w.center_y))
            n_outside++;
        else if (!have_best || run_sum < best_sum)
        begin
            best_sum  = run_sum;
            best_cx   = w.center_x;
            best_cy   = w.center_y;
            have_best = 1'b1;
        end
        cmp_ptr = 0;
        run_sum = '0;
        if (w.last_candidate)
        begin
            // cleared state is all zero, so a search with nothing inside reports zeros
            r.best_x   = best_cx;
            r.best_y   = best_cy;
            r.best_sad = best_sum;
            r.found    = have_best;
            pending_matches = {pending_matches, r};
            have_best = 1'b0;
            best_sum  = '0;
            best_cx   = '0;
            best_cy   = '0;
        end
    endfunction

    // ---------------------------------------------------------------- word builders

    function automatic pix_word_t load_word(input logic [23:0] rgb, input bit last);
        pix_word_t w;
        w                = '0;
        w.op             = OP_LOAD;
        {w.pixel_red, w.pixel_green, w.pixel_blue} = rgb;
        w.last_in_patch  = last;
        return w;
    endfunction

    function automatic pix_word_t cand_word(input logic [23:0] rgb, input logic [COORD_W-1:0] cx,
                                            input logic [COORD_W-1:0] cy, input bit last_pix,
                                            input bit last_cand);
        pix_word_t w;
        w                = '0;
        w.op             = OP_CAND;
        {w.pixel_red, w.pixel_green, w.pixel_blue} = rgb;
        w.center_x       = cx;
        w.center_y       = cy;
        w.last_in_patch  = last_pix;
        w.last_candidate = last_cand;
        return w;
    endfunction

    // centres cluster on the bounds edges and inside, with some fully random ones
    function automatic logic [COORD_W-1:0] pick_centre(input logic [CFG_W-1:0] extent);
        int h;
        int lim;
        int v;
        h   = HALF_SIDE << COORD_FRAC;
        lim = int'(32'(extent)) << COORD_FRAC;
        case ($urandom_range(0, 5))
            0:       v = h - 1 + int'($urandom_range(0, 1));
            1:       v = lim - h - 1 + int'($urandom_range(0, 1));
            2, 3:    v = lim - h > h ? int'($urandom_range(h, lim - h - 1)) : h;
            default: v = int'($urandom_range(0, 65535));
        endcase
        if (v < 0 || v > 65535)
            v = int'($urandom_range(0, 65535));
        return COORD_W'(v);
    endfunction

    // ---------------------------------------------------------------- channels

    // offer one pixel word, after a random gap when src_idle is set; hold it until the block takes it
    task automatic send_word(input pix_word_t w);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_word  <= w;
        do @(posedge clk); while (pix_stall);
        apply_pixel_word(w);
        n_words++;
    endtask

    // drop valid, let every expected result drain, then let the pipeline settle
    task automatic quiesce();
        pix_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high between back-to-back writes; the caller lowers it
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH:  img_w = val;
            CFG_IMAGE_HEIGHT: img_h = val;
            default:          ;
        endcase
    endtask

    task automatic set_image_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        quiesce();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
        n_sizes++;
    endtask

    // sink: after each taken result stall for a random number of cycles,
    // plus the long hold while the pressure test asks for it
    int unsigned sink_wait = 0;
    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
            sink_wait = sink_idle ? $urandom_range(0, 11) : 0;
        else if (sink_wait != 0)
            sink_wait--;
        res_stall <= hold_results || sink_wait != 0;
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // every taken result is compared with the oldest prediction
    always @(posedge clk)
    begin : result_check
        res_word_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_matches.size() == 0)
            begin
                $display("%0t unexpected result word: expected none, got %p", $time, res_word);
                n_errors++;
            end
            else
            begin
                want = pending_matches.pop_front();
                check_field("best_x", 32'(want.best_x), 32'(res_word.best_x));
                check_field("best_y", 32'(want.best_y), 32'(res_word.best_y));
                check_field("best_sad", 32'(want.best_sad), 32'(res_word.best_sad));
                check_field("found", 32'(want.found), 32'(res_word.found));
                n_results++;
            end
        end
    end

    // watchdog, and a count of cycles the block pushed back on its input
    always @(posedge clk)
    begin
        n_cycles++;
        if (pix_valid && pix_stall)
            n_stall_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("%0t run stopped after %0d cycles without finishing", $time, CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // reference prefix that every short candidate reads, extreme first pixels
    task automatic test_reference_load();
        logic [23:0] rgb;
        for (int i = 0; i < REF_LOAD_LEN; i++)
        begin
            rgb = i == 0 ? 24'h000000 : i == 1 ? 24'hFFFFFF : 24'($urandom);
            send_word(load_word(rgb, i == REF_LOAD_LEN - 1));
        end
    endtask

    // bounds edges, centre sampling, ties, centre extremes and the reload wrap
    task automatic test_directed_edges();
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ye;
        h  = COORD_W'(HALF_SIDE << COORD_FRAC);
        xe = COORD_W'((32'(img_w) << COORD_FRAC) - (HALF_SIDE << COORD_FRAC));
        ye = COORD_W'((32'(img_h) << COORD_FRAC) - (HALF_SIDE << COORD_FRAC));
        // one step short of the low edge: nothing found
        send_word(cand_word(24'h000000, h - 16'd1, h, 1'b1, 1'b1));
        // low edge, last position inside, first position past the high edge
        send_word(cand_word(24'hFFFFFF, h, h, 1'b1, 1'b0));
        send_word(cand_word(24'h123456, xe - 16'd1, ye - 16'd1, 1'b1, 1'b0));
        send_word(cand_word(24'h000000, xe, ye, 1'b1, 1'b1));
        // centre and last flag on a non-closing word are ignored; equal sums keep the first
        send_word(cand_word(24'h0055AA, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
        send_word(cand_word(24'hAA5500, 16'd1000, 16'd1000, 1'b1, 1'b0));
        send_word(cand_word(24'h0055AA, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(cand_word(24'hAA5500, 16'd2000, 16'd2000, 1'b1, 1'b1));
        // centre field extremes fall outside
        send_word(cand_word(24'hFFFFFF, 16'd0, 16'd0, 1'b1, 1'b0));
        send_word(cand_word(24'h000000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
        send_word(cand_word(24'h808080, xe - 16'd1, h, 1'b1, 1'b1));
        // only one axis outside
        send_word(cand_word(24'h010203, h, ye, 1'b1, 1'b0));
        send_word(cand_word(24'h010203, xe, h, 1'b1, 1'b1));
        // a closing load wraps: the next load lands on entry zero again
        send_word(load_word(24'h000000, 1'b0));
        send_word(load_word(24'hFFFFFF, 1'b1));
        send_word(load_word(24'hFF00FF, 1'b1));
        send_word(cand_word(24'hFFFFFF, 16'd500, 16'd500, 1'b0, 1'b0));
        send_word(cand_word(24'h000000, 16'd500, 16'd500, 1'b1, 1'b1));
    endtask

    // searches of one to four short candidates, some replayed for ties,
    // with reference reloads and junk fields mixed in
    task automatic random_searches(input int unsigned n);
        int unsigned stop;
        int unsigned n_cand;
        int unsigned len;
        int unsigned prev_len;
        int unsigned k;
        bit          replay;
        logic [23:0] prev_pix [MAX_LEN];
        logic [23:0] rgb;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        pix_word_t   w;
        stop     = n_words + n;
        prev_len = 0;
        while (n_words < stop)
        begin
            // switch pacing now and then so some stretches run without gaps
            if ($urandom_range(0, 7) == 0)
            begin
                src_idle   = $urandom_range(0, 3) != 0;
                sink_idle <= $urandom_range(0, 3) != 0;
            end
            n_cand = $urandom_range(1, 4);
            for (int c = 0; c < n_cand; c++)
            begin
                replay = prev_len != 0 && $urandom_range(0, 4) == 0;
                if (replay)
                    len = prev_len;
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(13, MAX_LEN);
                else
                    len = $urandom_range(1, 12);
                cx = pick_centre(img_w);
                cy = pick_centre(img_h);
                for (int p = 0; p < len; p++)
                begin
                    if ($urandom_range(0, 29) == 0)
                    begin
                        // reload in mid search, sometimes left open
                        k = $urandom_range(1, 3);
                        for (int q = 0; q < k; q++)
                        begin
                            w = load_word(24'($urandom), q == k - 1 && $urandom_range(0, 3) != 0);
                            w.center_x       = 16'($urandom);
                            w.center_y       = 16'($urandom);
                            w.last_candidate = 1'($urandom);
                            send_word(w);
                        end
                    end
                    rgb         = replay ? prev_pix[p] : 24'($urandom);
                    prev_pix[p] = rgb;
                    if (p == len - 1)
                        w = cand_word(rgb, cx, cy, 1'b1, c == n_cand - 1);
                    else
                        w = cand_word(rgb, 16'($urandom), 16'($urandom), 1'b0, 1'($urandom));
                    send_word(w);
                end
                prev_len = len;
            end
        end
    endtask

    // image size extremes, zero, the full register range and a few random sizes
    task automatic test_image_sizes();
        set_image_size(13'd4096, 13'd4096);
        random_searches(150);
        set_image_size(13'd1, 13'd1);
        random_searches(60);
        set_image_size(13'd40, 13'd48);
        random_searches(150);
        set_image_size(13'd0, 13'h1FFF);
        random_searches(60);
        repeat (3)
        begin
            set_image_size(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
            random_searches(80);
        end
        set_image_size(IMAGE_WIDTH_RESET, IMAGE_HEIGHT_RESET);
        random_searches(100);
    endtask

    // sink holds off for a long stretch while one-word searches keep coming,
    // so results pile up and the block has to stall its input
    task automatic test_result_backpressure();
        src_idle   = 1'b0;
        sink_idle <= 1'b0;
        fork
            begin
                hold_results <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results <= 1'b0;
            end
            for (int i = 0; i < 40; i++)
                send_word(cand_word(24'($urandom), pick_centre(img_w), pick_centre(img_h),
                                    1'b1, 1'b1));
        join
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reference_load();
        test_directed_edges();
        test_image_sizes();
        test_result_backpressure();
        quiesce();
        $display("checked %0d match results from %0d pixel words under %0d image sizes",
                 n_results, n_words, n_sizes);
        $display("%0d candidates fell outside the image, input pushed back for %0d cycles",
                 n_outside, n_stall_cycles);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
